// ----- design/dlrs_pkg.sv -----
// ----------------------------------------------------------------------------
// dlrs_pkg: shared types and constants of the double radix sorter
// Holds the fixed radix, the data width and the control bundles that the
// sequencer hands to the item buffers and to the bucket memory.
// ----------------------------------------------------------------------------
package dlrs_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int RADIX_BUCKETS = 256;
  localparam int DATA_W        = 64;
  localparam int KEY_W         = 8;

  typedef logic [KEY_W-1:0] key_t;

  // Control of the two ping-pong item buffers
  typedef struct packed {
    logic rd_sel;  // 0: buffer A, 1: buffer B
    logic wr_en;
    logic wr_sel;  // 0: buffer A, 1: buffer B
  } buf_ctl_t;

  // Control of the bucket count memory
  typedef struct packed {
    logic clear;   // drop all counts back to zero
    key_t rd_key;
    logic wr_en;
    key_t wr_key;
  } bkt_ctl_t;

endpackage

// ----- design/dlrs_in_if.sv -----
// ----------------------------------------------------------------------------
// dlrs_in_if: input item channel
// Carries one double bit pattern and its end-of-set mark per transfer.
// ----------------------------------------------------------------------------
interface dlrs_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic        last;

  modport source (output valid, output value_bits, output last, input ready);
  modport sink   (input valid, input value_bits, input last, output ready);
endinterface

// ----- design/dlrs_out_if.sv -----
// ----------------------------------------------------------------------------
// dlrs_out_if: result item channel
// Carries one sorted double bit pattern per transfer, with burst marks.
// ----------------------------------------------------------------------------
interface dlrs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] sorted_bits;
  logic        last_res;
  logic        overflow;

  modport source (output valid, output sorted_bits, output last_res, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_bits, input last_res, input overflow,
                  output ready);
endinterface

// ----- design/dlrs_buffers.sv -----
// ----------------------------------------------------------------------------
// dlrs_buffers: ping-pong item buffers
// Two single-port-write memories; both are read at one shared address with a
// registered read, and the selected buffer is muxed at the output.
// ----------------------------------------------------------------------------
module dlrs_buffers #(
  parameter int MAX_ITEMS = dlrs_pkg::MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  dlrs_pkg::buf_ctl_t           ctl,
  input  logic [$clog2(MAX_ITEMS)-1:0] rd_addr,
  input  logic [$clog2(MAX_ITEMS)-1:0] wr_addr,
  input  logic [dlrs_pkg::DATA_W-1:0]  wr_data,
  output logic [dlrs_pkg::DATA_W-1:0]  rd_data
);
  import dlrs_pkg::*;

  logic [DATA_W-1:0] buf_a [MAX_ITEMS];
  logic [DATA_W-1:0] buf_b [MAX_ITEMS];
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  logic              rd_sel;

  // Write the selected buffer, read both at the shared address
  always_ff @(posedge clk) begin
    if (ctl.wr_en && !ctl.wr_sel) begin
      buf_a[wr_addr] <= wr_data;
    end
    if (ctl.wr_en && ctl.wr_sel) begin
      buf_b[wr_addr] <= wr_data;
    end
    rd_a   <= buf_a[rd_addr];
    rd_b   <= buf_b[rd_addr];
    rd_sel <= ctl.rd_sel;
  end

  assign rd_data = rd_sel ? rd_b : rd_a;

endmodule

// ----- design/dlrs_bucket_ram.sv -----
// ----------------------------------------------------------------------------
// dlrs_bucket_ram: 256-entry bucket count memory
// Registered read with write-through bypass for a write to the key being read
// in the same cycle. Per-bucket valid flops make a cleared bucket read zero.
// ----------------------------------------------------------------------------
module dlrs_bucket_ram #(
  parameter int MAX_ITEMS = dlrs_pkg::MAX_ITEMS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  dlrs_pkg::bkt_ctl_t             ctl,
  input  logic [$clog2(MAX_ITEMS+1)-1:0] wr_data,
  output logic [$clog2(MAX_ITEMS+1)-1:0] rd_data
);
  import dlrs_pkg::*;

  localparam int CW = $clog2(MAX_ITEMS + 1);

  logic [CW-1:0]            mem [RADIX_BUCKETS];
  logic [RADIX_BUCKETS-1:0] vld;
  logic [CW-1:0]            mem_q;
  logic [CW-1:0]            byp_data;
  logic                     byp_hit;
  logic                     vld_q;

  // Memory array and registered read
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_key] <= wr_data;
    end
    mem_q    <= mem[ctl.rd_key];
    byp_data <= wr_data;
  end

  // Valid bits and bypass flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      vld_q   <= 1'b0;
      byp_hit <= 1'b0;
    end else begin
      if (ctl.clear) begin
        vld <= '0;
      end else if (ctl.wr_en) begin
        vld[ctl.wr_key] <= 1'b1;
      end
      vld_q   <= vld[ctl.rd_key];
      byp_hit <= ctl.wr_en && (ctl.wr_key == ctl.rd_key);
    end
  end

  // Forward a same-cycle write, else memory data or zero for a cleared bucket
  assign rd_data = byp_hit ? byp_data : (vld_q ? mem_q : '0);

endmodule

// ----- design/double_lsd_radix_sort.sv -----
// ----------------------------------------------------------------------------
// double_lsd_radix_sort: burst sorter for IEEE-754 double bit patterns
// Loads a set, sorts it by eight stable byte passes and emits it in order.
// ----------------------------------------------------------------------------
// Items are taken one per cycle until one marked last; up to MAX_ITEMS are
// kept and any beyond that are dropped, which sets overflow on every result
// of that burst. The set of n items is then sorted as unsigned 64-bit words
// by eight counting passes, low byte first. Each pass is a bucket clear, a
// histogram sweep over the item buffers, a prefix sweep of the 256-entry
// bucket memory at one bucket a cycle, and a scatter sweep over the item
// buffers. Each result is then read from the item buffers and loaded into
// the output register; the next read starts as the sink takes the previous
// result. The prefix sweeps dominate the sorting time for small sets. The
// output order puts negative values and NaNs first (most negative first) and
// then the values >= 0.0; +0.0 is always among the non-negatives, and -0.0
// joins them unless the set holds a positive NaN, which pulls -0.0 into the
// leading part. No input is taken from the last item until the burst's final
// result has been loaded into the output register.
// ----------------------------------------------------------------------------
module double_lsd_radix_sort #(
  parameter int MAX_ITEMS = dlrs_pkg::MAX_ITEMS_DEF
) (
  input logic        clk,
  input logic        rst,
  dlrs_in_if.sink    items,
  dlrs_out_if.source results
);
  import dlrs_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = $clog2(RADIX_BUCKETS + 1);
  localparam logic [62:0] INF_MAG = 63'h7FF0_0000_0000_0000;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CLEAR,
    S_HIST,
    S_PREFIX,
    S_SCAT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  state_t            state;
  logic [CW-1:0]     item_count;
  logic              dropped;
  logic              burst_ovf;
  logic [CW-1:0]     c_pos;
  logic [CW-1:0]     c_pnan;
  logic [CW-1:0]     c_nzero;
  logic [2:0]        pass;
  logic [CW-1:0]     iss_idx;
  logic              s1_valid;
  logic              s2_valid;
  key_t              s2_key;
  logic [DATA_W-1:0] s2_data;
  logic [PW-1:0]     pidx;
  logic              p1_valid;
  key_t              p1_key;
  logic [CW-1:0]     pos;
  logic [CW-1:0]     split_index;
  logic [CW-1:0]     tail_left;
  logic [CW-1:0]     head_idx;
  logic [CW-1:0]     rem;
  logic              pend_last;
  logic              out_valid;
  logic [DATA_W-1:0] out_bits;
  logic              out_last;
  logic              out_ovf;

  buf_ctl_t          bctl;
  logic [AW-1:0]     buf_rd_addr;
  logic [AW-1:0]     buf_wr_addr;
  logic [DATA_W-1:0] buf_wr_data;
  logic [DATA_W-1:0] buf_rd_data;
  bkt_ctl_t          kctl;
  logic [CW-1:0]     bkt_wr_data;
  logic [CW-1:0]     bkt_rd_data;

  logic              in_xfer;
  logic              out_xfer;
  logic              sweep;
  logic              iss_go;
  logic              emit_go;
  logic              store_ok;
  logic              v_sign;
  logic              v_nan;
  key_t              s1_key;
  logic [CW-1:0]     emit_addr;
  logic [CW-1:0]     split_calc;

  // Handshakes and sweep control
  assign items.ready = (state == S_LOAD);
  assign in_xfer     = items.valid && (state == S_LOAD);
  assign out_xfer    = out_valid && results.ready;
  assign sweep       = (state == S_HIST) || (state == S_SCAT);
  assign iss_go      = sweep && (iss_idx < item_count);
  assign emit_go     = (state == S_EMIT_RD) && (!out_valid || results.ready);
  assign store_ok    = item_count < CW'(MAX_ITEMS);

  // Classify the incoming pattern for the split point
  assign v_sign = items.value_bits[63];
  assign v_nan  = items.value_bits[62:0] > INF_MAG;

  // Digit of the current pass from the item just read
  assign s1_key = buf_rd_data[{pass, 3'b000} +: KEY_W];

  // Sorted order: +0..+inf, +NaN, -0, negatives, -NaN
  assign split_calc = c_pos + ((c_pnan == '0) ? c_nzero : '0);

  // Emission address: tail from the top down, then the head upward
  assign emit_addr = (tail_left != '0) ? (split_index + tail_left - CW'(1)) : head_idx;

  // Drive the item buffers
  always_comb begin
    bctl.rd_sel = sweep ? pass[0] : 1'b0;
    bctl.wr_en  = 1'b0;
    bctl.wr_sel = 1'b0;
    buf_rd_addr = (state == S_EMIT_RD) ? emit_addr[AW-1:0] : iss_idx[AW-1:0];
    buf_wr_addr = item_count[AW-1:0];
    buf_wr_data = items.value_bits;
    if (in_xfer && store_ok) begin
      bctl.wr_en = 1'b1;
    end else if ((state == S_SCAT) && s2_valid) begin
      bctl.wr_en  = 1'b1;
      bctl.wr_sel = ~pass[0];
      buf_wr_addr = bkt_rd_data[AW-1:0];
      buf_wr_data = s2_data;
    end
  end

  // Drive the bucket memory
  always_comb begin
    kctl.clear  = (state == S_CLEAR);
    kctl.rd_key = (state == S_PREFIX) ? pidx[KEY_W-1:0] : s1_key;
    kctl.wr_en  = (sweep && s2_valid) || ((state == S_PREFIX) && p1_valid);
    kctl.wr_key = (state == S_PREFIX) ? p1_key : s2_key;
    bkt_wr_data = (state == S_PREFIX) ? pos : (bkt_rd_data + CW'(1));
  end

  dlrs_buffers #(.MAX_ITEMS(MAX_ITEMS)) u_buffers (
    .clk     (clk),
    .ctl     (bctl),
    .rd_addr (buf_rd_addr),
    .wr_addr (buf_wr_addr),
    .wr_data (buf_wr_data),
    .rd_data (buf_rd_data)
  );

  dlrs_bucket_ram #(.MAX_ITEMS(MAX_ITEMS)) u_buckets (
    .clk     (clk),
    .rst     (rst),
    .ctl     (kctl),
    .wr_data (bkt_wr_data),
    .rd_data (bkt_rd_data)
  );

  // Sequencer, sweep pipeline and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      item_count  <= '0;
      dropped     <= 1'b0;
      burst_ovf   <= 1'b0;
      c_pos       <= '0;
      c_pnan      <= '0;
      c_nzero     <= '0;
      pass        <= '0;
      iss_idx     <= '0;
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s2_key      <= '0;
      s2_data     <= '0;
      pidx        <= '0;
      p1_valid    <= 1'b0;
      p1_key      <= '0;
      pos         <= '0;
      split_index <= '0;
      tail_left   <= '0;
      head_idx    <= '0;
      rem         <= '0;
      pend_last   <= 1'b0;
      out_valid   <= 1'b0;
      out_bits    <= '0;
      out_last    <= 1'b0;
      out_ovf     <= 1'b0;
    end else begin
      // Advance the sweep pipelines
      s1_valid <= iss_go;
      s2_valid <= s1_valid;
      s2_key   <= s1_key;
      s2_data  <= buf_rd_data;
      p1_valid <= (state == S_PREFIX) && (pidx < PW'(RADIX_BUCKETS));
      p1_key   <= pidx[KEY_W-1:0];

      // Drop the result once the sink takes it
      if (out_xfer) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (in_xfer) begin
            if (store_ok) begin
              item_count <= item_count + CW'(1);
              c_pos      <= c_pos + CW'(!v_sign && !v_nan);
              c_pnan     <= c_pnan + CW'(!v_sign && v_nan);
              c_nzero    <= c_nzero + CW'(v_sign && (items.value_bits[62:0] == '0));
            end else if (!items.last) begin
              dropped <= 1'b1;
            end
            if (items.last) begin
              burst_ovf <= dropped || !store_ok;
              dropped   <= 1'b0;
              pass      <= '0;
              state     <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          iss_idx <= '0;
          state   <= S_HIST;
        end
        S_HIST: begin
          if (iss_go) begin
            iss_idx <= iss_idx + CW'(1);
          end
          if (!iss_go && !s1_valid && !s2_valid) begin
            pidx  <= '0;
            pos   <= '0;
            state <= S_PREFIX;
          end
        end
        S_PREFIX: begin
          if (pidx < PW'(RADIX_BUCKETS)) begin
            pidx <= pidx + PW'(1);
          end
          if (p1_valid) begin
            pos <= pos + bkt_rd_data;
          end
          if ((pidx == PW'(RADIX_BUCKETS)) && !p1_valid) begin
            iss_idx <= '0;
            state   <= S_SCAT;
          end
        end
        S_SCAT: begin
          if (iss_go) begin
            iss_idx <= iss_idx + CW'(1);
          end
          if (!iss_go && !s1_valid && !s2_valid) begin
            if (pass == 3'd7) begin
              split_index <= split_calc;
              tail_left   <= item_count - split_calc;
              head_idx    <= '0;
              rem         <= item_count;
              state       <= S_EMIT_RD;
            end else begin
              pass  <= pass + 3'd1;
              state <= S_CLEAR;
            end
          end
        end
        S_EMIT_RD: begin
          if (emit_go) begin
            rem       <= rem - CW'(1);
            pend_last <= (rem == CW'(1));
            if (tail_left != '0) begin
              tail_left <= tail_left - CW'(1);
            end else begin
              head_idx <= head_idx + CW'(1);
            end
            state <= S_EMIT_LD;
          end
        end
        S_EMIT_LD: begin
          out_valid <= 1'b1;
          out_bits  <= buf_rd_data;
          out_last  <= pend_last;
          out_ovf   <= burst_ovf;
          if (pend_last) begin
            item_count <= '0;
            c_pos      <= '0;
            c_pnan     <= '0;
            c_nzero    <= '0;
            state      <= S_LOAD;
          end else begin
            state <= S_EMIT_RD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  assign results.valid       = out_valid;
  assign results.sorted_bits = out_bits;
  assign results.last_res    = out_last;
  assign results.overflow    = out_ovf;

  // Store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CW'(MAX_ITEMS))
    else $error("item count beyond capacity");

  // Prefix sweep accounts for every stored item
  a_prefix_total: assert property (@(posedge clk) disable iff (rst)
    ((state == S_PREFIX) && (pidx == PW'(RADIX_BUCKETS)) && !p1_valid)
      |-> (pos == item_count))
    else $error("bucket histogram total differs from item count");

  // Scatter writes land inside the stored range
  a_scatter_addr: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAT) && s2_valid) |-> (bkt_rd_data < item_count))
    else $error("scatter position outside stored items");

  // A result appears only from the emission load step
  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT_LD))
    else $error("result raised outside emission");

endmodule

// ----- tb/sort_check_pkg.sv -----
// ----------------------------------------------------------------------------
// sort_check_pkg: expected-burst tracker for the double radix sorter
// Collects each set of doubles as it is transferred in, orders it the way the
// sorter must emit it, and checks every result transfer against that order.
// ----------------------------------------------------------------------------
package sort_check_pkg;

  import dlrs_pkg::*;

  typedef logic [DATA_W-1:0] dbl_bits_t;

  typedef struct {
    dbl_bits_t bits;
    logic      last_mark;
    logic      ovf;
  } sorted_word_t;

  class sort_scoreboard;
    dbl_bits_t    held_set[$];
    logic         lost_items;
    sorted_word_t awaited[$];
    int unsigned  fail_count;
    int unsigned  checked_count;
    int unsigned  burst_count;
    int unsigned  overflow_bursts;

    function new();
      lost_items      = 1'b0;
      fail_count      = 0;
      checked_count   = 0;
      burst_count     = 0;
      overflow_bursts = 0;
    endfunction

    // True when the pattern compares >= 0.0; both zeros qualify, NaNs never
    static function bit at_least_zero(dbl_bits_t b);
      dbl_bits_t mag;
      mag = {1'b0, b[DATA_W-2:0]};
      if (mag == '0)
        return 1'b1;
      if (mag > 64'h7FF0_0000_0000_0000)
        return 1'b0;
      return !b[DATA_W-1];
    endfunction

    function void report_fail(string msg);
      fail_count++;
      if (fail_count <= 10)
        $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    // Store one input transfer; on the end-of-set mark, queue the whole burst
    function void note_item(dbl_bits_t v, logic l);
      dbl_bits_t    ordered[$];
      dbl_bits_t    emit_order[$];
      int           first_neg;
      int           n;
      sorted_word_t w;
      if (held_set.size() < MAX_ITEMS_DEF)
        held_set = {held_set, v};
      else
        lost_items = 1'b1;
      if (!l)
        return;

      // Order as unsigned words, then find where the negatives and NaNs start
      ordered = held_set;
      ordered.sort();
      n = ordered.size();
      first_neg = 0;
      while (first_neg < n && at_least_zero(ordered[first_neg]))
        first_neg++;

      // Emit the tail backwards, then the head in order
      for (int k = n - 1; k >= first_neg; k--)
        emit_order = {emit_order, ordered[k]};
      for (int i = 0; i < first_neg; i++)
        emit_order = {emit_order, ordered[i]};
      for (int j = 0; j < n; j++) begin
        w.bits      = emit_order[j];
        w.last_mark = (j == n - 1);
        w.ovf       = lost_items;
        awaited     = {awaited, w};
      end

      burst_count++;
      if (lost_items)
        overflow_bursts++;
      held_set.delete();
      lost_items = 1'b0;
    endfunction

    // Compare one result transfer with the oldest expected word
    function void check_result(dbl_bits_t bits, logic lr, logic ovf);
      sorted_word_t w;
      checked_count++;
      if (awaited.size() == 0) begin
        report_fail($sformatf("unexpected result sorted_bits=%h last_res=%b overflow=%b",
                              bits, lr, ovf));
        return;
      end
      w = awaited.pop_front();
      if (bits !== w.bits)
        report_fail($sformatf("result %0d sorted_bits: expected %h, got %h",
                              checked_count, w.bits, bits));
      if (lr !== w.last_mark)
        report_fail($sformatf("result %0d last_res: expected %b, got %b",
                              checked_count, w.last_mark, lr));
      if (ovf !== w.ovf)
        report_fail($sformatf("result %0d overflow: expected %b, got %b",
                              checked_count, w.ovf, ovf));
    endfunction

    function void final_check();
      if (held_set.size() != 0)
        report_fail($sformatf("%0d items transferred without an end-of-set mark",
                              held_set.size()));
      if (awaited.size() != 0)
        report_fail($sformatf("%0d expected results never arrived", awaited.size()));
    endfunction
  endclass

endpackage

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for double_lsd_radix_sort
// Feeds sets of double bit patterns (zeros, infinities, NaNs, denormals,
// duplicates, byte-level near neighbors, full random words), including full
// and over-full sets, with random gaps on input and random stalls on output.
// Every result transfer is checked against the expected sorted burst.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sort_check_pkg::*;

  localparam int IDLE_PCT     = 31;
  localparam int QUIET_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 210;
  localparam int DRAIN_CYCLES = 64;

  localparam dbl_bits_t POS_ZERO   = 64'h0000_0000_0000_0000;
  localparam dbl_bits_t NEG_ZERO   = 64'h8000_0000_0000_0000;
  localparam dbl_bits_t POS_ONE    = 64'h3FF0_0000_0000_0000;
  localparam dbl_bits_t NEG_ONE    = 64'hBFF0_0000_0000_0000;
  localparam dbl_bits_t POS_TWO    = 64'h4000_0000_0000_0000;
  localparam dbl_bits_t NEG_TWO    = 64'hC000_0000_0000_0000;
  localparam dbl_bits_t POS_INF    = 64'h7FF0_0000_0000_0000;
  localparam dbl_bits_t NEG_INF    = 64'hFFF0_0000_0000_0000;
  localparam dbl_bits_t QUIET_NAN  = 64'h7FF8_0000_0000_0000;
  localparam dbl_bits_t SIG_NAN    = 64'h7FF0_0000_0000_0001;
  localparam dbl_bits_t NEG_NAN    = 64'hFFF8_0000_0000_0000;
  localparam dbl_bits_t ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam dbl_bits_t MIN_DENORM = 64'h0000_0000_0000_0001;
  localparam dbl_bits_t MAX_FINITE = 64'h7FEF_FFFF_FFFF_FFFF;
  localparam dbl_bits_t TOP_NAN    = 64'h7FFF_FFFF_FFFF_FFFF;

  logic        clk = 1'b0;
  logic        rst;
  logic        sender_steady;
  logic        receiver_steady;
  int unsigned sent_items;
  int unsigned results_seen;
  int unsigned quiet_cycles;

  dlrs_in_if  in_ch ();
  dlrs_out_if out_ch ();

  double_lsd_radix_sort DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch)
  );

  sort_scoreboard sb;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result channel at random, except for one steady stretch
  assign receiver_steady = (results_seen >= 150) && (results_seen < 300);

  always @(posedge clk) begin
    if (rst)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= receiver_steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Record input transfers and check result transfers
  always @(posedge clk) begin
    if (rst) begin
      results_seen <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        sb.note_item(in_ch.value_bits, in_ch.last);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.sorted_bits, out_ch.last_res, out_ch.overflow);
        results_seen <= results_seen + 1;
      end
    end
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item, with an optional random gap first, and hold until taken
  task automatic send_item(input dbl_bits_t v, input logic l);
    while (!sender_steady && ($urandom_range(99) < IDLE_PCT)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value_bits <= v;
    in_ch.last       <= l;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    sent_items++;
  endtask

  task automatic send_set(input dbl_bits_t vals[$]);
    for (int i = 0; i < vals.size(); i++)
      send_item(vals[i], i == vals.size() - 1);
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0)
      @(posedge clk);
  endtask

  // Draw one pattern, weighted toward the classes that matter to the split
  function automatic dbl_bits_t pick_double(dbl_bits_t prev);
    dbl_bits_t v;
    logic      s;
    int        b;
    s = 1'($urandom_range(1));
    v = {$urandom, $urandom};
    b = $urandom_range(7);
    case ($urandom_range(9))
      0: v = {s, 63'h0};
      1: v = {s, 11'h7FF, 52'h0};
      2: v = {s, 11'h7FF, v[51:1], 1'b1};
      3: v = {s, 11'h000, v[51:0]};
      4: v = prev;
      5: begin
        v = prev;
        v[8*b +: 8] = 8'($urandom);
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    dbl_bits_t set_q[$];
    dbl_bits_t prev;
    int        set_no;
    int        set_size;
    int        directed_items;

    sb = new();
    rst              = 1'b1;
    sender_steady    = 1'b0;
    sent_items       = 0;
    in_ch.valid      = 1'b0;
    in_ch.value_bits = '0;
    in_ch.last       = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed sets: lone elements, all non-negative, all negative, extremes
    set_q = '{POS_ZERO};
    send_set(set_q);
    set_q = '{NEG_NAN};
    send_set(set_q);
    set_q = '{POS_TWO, POS_ONE};
    send_set(set_q);
    set_q = '{NEG_ONE, NEG_TWO};
    send_set(set_q);
    set_q = '{NEG_ZERO, POS_ONE, NEG_ONE, POS_INF, NEG_INF, QUIET_NAN, SIG_NAN,
              ALL_ONES, MIN_DENORM, MAX_FINITE, POS_ZERO, NEG_ZERO, TOP_NAN};
    send_set(set_q);
    directed_items = sent_items;

    // Random sets: mostly small, one full set and one that overruns capacity
    set_no = 0;
    prev   = POS_ONE;
    while (sent_items < directed_items + RANDOM_ITEMS) begin
      if (set_no == 1)
        set_size = dlrs_pkg::MAX_ITEMS_DEF;
      else if (set_no == 5)
        set_size = dlrs_pkg::MAX_ITEMS_DEF + $urandom_range(1, 6);
      else if ($urandom_range(9) == 0)
        set_size = $urandom_range(11, 30);
      else
        set_size = $urandom_range(1, 10);

      sender_steady = (set_no >= 8) && (set_no < 13);
      if (set_no == 3 || $urandom_range(5) == 0)
        wait_drained();

      set_q.delete();
      for (int i = 0; i < set_size; i++) begin
        prev  = pick_double(prev);
        set_q = {set_q, prev};
      end
      send_set(set_q);
      set_no++;
    end

    // Drain the last burst, then allow for any stray results
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.final_check();

    $display("Sorted %0d sets (%0d over capacity) from %0d input items; %0d results checked",
             sb.burst_count, sb.overflow_bursts, sent_items, sb.checked_count);
    if (sb.fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
